/* rtl/hso_pkg.sv */
// Shared types, constants and tables for the horizon sweep occlusion block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package hso_pkg;

   localparam int MaxPath     = 1024;
   localparam int PathBits    = 10;
   localparam int GridBits    = 10;
   localparam int CordicSteps = 16;

   // Q.24 unit for the CORDIC vector and the clamp limit of the angle.
   localparam logic signed [27:0] CordicOne   = 28'sd16777216;
   localparam logic signed [21:0] QuarterHalf = 22'sd524288;
   localparam logic signed [17:0] OneQ16      = 18'sd65536;
   localparam logic [30:0]        CompLimit   = 31'h7FFF_FFFF;

   typedef struct packed {
      logic              sweep_start;
      logic signed [11:0] col;
      logic signed [11:0] row;
      logic signed [23:0] height;
   } req_type;

   typedef struct packed {
      logic [12:0] occlusion_part;
      logic [9:0]  out_col;
      logic [9:0]  out_row;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] col;
      logic signed [11:0] row;
      logic signed [23:0] height;
   } point_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_LAUNCH, ST_CALC, ST_CORDIC, ST_PUSH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      SL_IDLE, SL_MX, SL_MY, SL_SQX, SL_SQY, SL_SQZ, SL_SUM,
      SL_ROOT, SL_DINIT, SL_DIV, SL_DONE
   } slope_state_type;

   // Arctangent table, angle unit pi/2 = 2^20.
   function automatic logic [19:0] cordic_angle(input logic [3:0] idx);
      logic [19:0] a;
      case (idx)
         4'd0:    a = 20'd524288;
         4'd1:    a = 20'd309505;
         4'd2:    a = 20'd163534;
         4'd3:    a = 20'd83012;
         4'd4:    a = 20'd41667;
         4'd5:    a = 20'd20854;
         4'd6:    a = 20'd10430;
         4'd7:    a = 20'd5215;
         4'd8:    a = 20'd2608;
         4'd9:    a = 20'd1304;
         4'd10:   a = 20'd652;
         4'd11:   a = 20'd326;
         4'd12:   a = 20'd163;
         4'd13:   a = 20'd81;
         4'd14:   a = 20'd41;
         4'd15:   a = 20'd20;
         default: a = 20'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* rtl/hso_slope.sv */
// Iterative 3D slope unit: distance by shared multiplier, bit-serial square
// root and restoring division. Depends on hso_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hso_slope import hso_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [23:0]       cell_size,
   input  wire point_type         pt_a,
   input  wire point_type         pt_b,
   output logic                   done,
   output logic signed [17:0]     slope
);

   slope_state_type state_ff, state_in;

   logic [11:0]        dc_ff, dr_ff;
   logic signed [24:0] dz_ff;
   logic [23:0]        cs_ff;
   logic [63:0]        prod_ff, acc_ff, root_ff;
   logic [30:0]        mx_ff, my_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        drem_ff;
   logic [16:0]        q_ff;

   logic signed [12:0] dcol, drow;
   logic signed [24:0] dz;
   logic [24:0]        mz;
   logic [31:0]        op_a, op_b;
   logic [30:0]        prod_sat;
   logic [63:0]        bitv, trial;
   logic [40:0]        num;
   logic [32:0]        dtrial;
   logic [31:0]        len;

   // Differences between the two points at launch.
   always_comb begin
      dcol = {pt_a.col[11], pt_a.col} - {pt_b.col[11], pt_b.col};
      drow = {pt_a.row[11], pt_a.row} - {pt_b.row[11], pt_b.row};
      dz   = {pt_a.height[23], pt_a.height} - {pt_b.height[23], pt_b.height};
   end

   // Working values derived from the latched differences.
   always_comb begin
      mz       = dz_ff[24] ? 25'(-dz_ff) : 25'(dz_ff);
      num      = {mz[24:0], 16'd0};
      prod_sat = (prod_ff > {33'd0, CompLimit}) ? CompLimit : prod_ff[30:0];
      bitv     = 64'd1 << {cnt_ff, 1'b0};
      trial    = root_ff + bitv;
      len      = root_ff[31:0];
      dtrial   = {drem_ff, num[cnt_ff]};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SL_IDLE:  if (start) state_in = SL_MX;
         SL_MX:    state_in = SL_MY;
         SL_MY:    state_in = SL_SQX;
         SL_SQX:   state_in = SL_SQY;
         SL_SQY:   state_in = SL_SQZ;
         SL_SQZ:   state_in = SL_SUM;
         SL_SUM:   state_in = SL_ROOT;
         SL_ROOT:  if (cnt_ff == 5'd0) state_in = SL_DINIT;
         SL_DINIT: state_in = SL_DIV;
         SL_DIV:   if (cnt_ff == 5'd0) state_in = SL_DONE;
         SL_DONE:  state_in = SL_IDLE;
         default:  state_in = SL_IDLE;
      endcase
   end

   // Multiplier operand selection and outputs.
   always_comb begin
      op_a = 32'd0;
      op_b = 32'd0;
      done = 1'b0;
      case (state_ff)
         SL_MX:   begin op_a = {20'd0, dc_ff}; op_b = {8'd0, cs_ff}; end
         SL_MY:   begin op_a = {20'd0, dr_ff}; op_b = {8'd0, cs_ff}; end
         SL_SQX:  begin op_a = {1'b0, mx_ff};  op_b = {1'b0, mx_ff}; end
         SL_SQY:  begin op_a = {1'b0, my_ff};  op_b = {1'b0, my_ff}; end
         SL_SQZ:  begin op_a = {7'd0, mz};     op_b = {7'd0, mz}; end
         SL_DONE: done = 1'b1;
         default: ;
      endcase
      if (len == 32'd0)
         slope = 18'sd0;
      else if (dz_ff > 25'sd0)
         slope = -$signed({1'b0, q_ff});
      else
         slope = $signed({1'b0, q_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      case (state_ff)
         SL_IDLE: begin
            dc_ff <= dcol[12] ? 12'(-dcol) : 12'(dcol);
            dr_ff <= drow[12] ? 12'(-drow) : 12'(drow);
            dz_ff <= dz;
            cs_ff <= cell_size;
         end
         SL_MY:  mx_ff  <= prod_sat;
         SL_SQX: my_ff  <= prod_sat;
         SL_SQY: acc_ff <= prod_ff;
         SL_SQZ: acc_ff <= acc_ff + prod_ff;
         SL_SUM: begin
            acc_ff  <= acc_ff + prod_ff;
            root_ff <= 64'd0;
            cnt_ff  <= 5'd31;
         end
         SL_ROOT: begin
            if (acc_ff >= trial) begin
               acc_ff  <= acc_ff - trial;
               root_ff <= (root_ff >> 1) + bitv;
            end else begin
               root_ff <= root_ff >> 1;
            end
            cnt_ff <= cnt_ff - 5'd1;
         end
         SL_DINIT: begin
            drem_ff <= {8'd0, num[40:17]};
            q_ff    <= 17'd0;
            cnt_ff  <= 5'd16;
         end
         SL_DIV: begin
            if (dtrial >= {1'b0, len}) begin
               drem_ff <= 32'(dtrial - {1'b0, len});
               q_ff    <= {q_ff[15:0], 1'b1};
            end else begin
               drem_ff <= dtrial[31:0];
               q_ff    <= {q_ff[15:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 5'd1;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/horizon_sweep_occlusion_top.sv */
// Top level of the horizon sweep occlusion block: hull memory, pop sequencer,
// CORDIC arctangent and result register. Depends on hso_pkg and hso_slope.
//
// Each non-start request computes one slope to the hull top and one more for
// every hull point it compares against, so k pops cost k + 2 slopes, or k + 1
// when the pops reach the bottom entry. Each slope is a memory fetch, a launch
// and a run of the shared multiply / square-root / divide unit; the CORDIC and
// the push follow, and the next request can be taken only after the push, which
// waits until the response register is free or being read. A start request is
// written to the hull as it is accepted. The hull lives in a 1024-entry memory
// with registered reads; no clearing pass is needed after reset. A new request
// is taken while the last response still waits.
`timescale 1ns / 1ps
`default_nettype none
module horizon_sweep_occlusion_top import hso_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata
);

   ctrl_state_type state_ff, state_in;

   logic [23:0]         cell_size_ff;
   point_type           pt_ff;
   logic [PathBits-1:0] top_ff, work_ff;
   logic                second_ff;
   logic signed [17:0]  s1_ff;
   logic signed [27:0]  x_ff, y_ff;
   logic signed [21:0]  z_ff;
   logic [3:0]          cnt_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   point_type           mem [MaxPath];
   point_type           rd_data_ff;
   logic [PathBits-1:0] rd_addr, wr_addr, push_idx;
   logic                mem_we;
   point_type           wr_data;

   logic                accept, slope_start, slope_done;
   logic signed [17:0]  slope_out;
   logic                pop, cordic_go;
   logic signed [17:0]  sine, sine_c;
   logic signed [27:0]  xs, ys;
   logic signed [21:0]  ang;
   logic signed [21:0]  z_c;
   logic [20:0]         z_round;
   logic                push_ok;
   rsp_type             rsp_new;

   // Hull memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   hso_slope u_slope (
      .clock     (clock),
      .reset     (reset),
      .start     (slope_start),
      .cell_size (cell_size_ff),
      .pt_a      (pt_ff),
      .pt_b      (rd_data_ff),
      .done      (slope_done),
      .slope     (slope_out)
   );

   // Pop decision and horizon selection when a slope finishes.
   always_comb begin
      accept    = req_valid && req_ready;
      pop       = second_ff && (s1_ff < slope_out);
      cordic_go = 1'b0;
      sine      = s1_ff;
      if (state_ff == ST_CALC && slope_done) begin
         if (!second_ff) begin
            cordic_go = (work_ff == '0);
            sine      = slope_out;
         end else if (!pop) begin
            cordic_go = 1'b1;
            sine      = s1_ff;
         end else begin
            cordic_go = (work_ff == PathBits'(1));
            sine      = slope_out;
         end
      end
      if (sine < 18'sd0)
         sine_c = 18'sd0;
      else if (sine > OneQ16)
         sine_c = OneQ16;
      else
         sine_c = sine;
   end

   // CORDIC step, final angle rounding, push index and response fields.
   always_comb begin
      xs      = x_ff >>> cnt_ff;
      ys      = (y_ff < 28'sd0) ? -((-y_ff) >>> cnt_ff) : (y_ff >>> cnt_ff);
      ang     = $signed({2'b00, cordic_angle(cnt_ff)});
      if (z_ff < 22'sd0)
         z_c = 22'sd0;
      else if (z_ff > QuarterHalf)
         z_c = QuarterHalf;
      else
         z_c = z_ff;
      z_round = 21'(z_c) + 21'd128;
      push_idx = (work_ff == PathBits'(MaxPath - 1)) ? work_ff : work_ff + 1'b1;
      push_ok  = !rsp_valid_ff || rsp_ready;
      rsp_new.occlusion_part = z_round[20:8];
      rsp_new.out_col = pt_ff.col[11] ? '0 :
                        (pt_ff.col > 12'sd1023) ? GridBits'(1023) : pt_ff.col[9:0];
      rsp_new.out_row = pt_ff.row[11] ? '0 :
                        (pt_ff.row > 12'sd1023) ? GridBits'(1023) : pt_ff.row[9:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept && !req_data.sweep_start) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_CALC;
         ST_CALC: begin
            if (slope_done) state_in = cordic_go ? ST_CORDIC : ST_FETCH;
         end
         ST_CORDIC: if (cnt_ff == 4'(CordicSteps - 1)) state_in = ST_PUSH;
         ST_PUSH:   if (push_ok) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control strobes and memory port selection.
   always_comb begin
      req_ready   = 1'b0;
      slope_start = 1'b0;
      mem_we      = 1'b0;
      wr_addr     = push_idx;
      wr_data     = pt_ff;
      rd_addr     = second_ff ? work_ff - 1'b1 : work_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && req_data.sweep_start) begin
               mem_we  = 1'b1;
               wr_addr = '0;
               wr_data = '{col: req_data.col, row: req_data.row,
                           height: req_data.height};
            end
         end
         ST_LAUNCH: slope_start = 1'b1;
         ST_PUSH:   mem_we = push_ok;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cell_size_ff <= 24'd64;
         second_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) cell_size_ff <= csr_wdata;
         if (state_ff == ST_PUSH && push_ok) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               second_ff <= 1'b0;
               if (accept && req_data.sweep_start) top_ff <= '0;
            end
            ST_CALC: if (slope_done) second_ff <= 1'b1;
            ST_PUSH: if (push_ok) top_ff <= push_idx;
            default: ;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            pt_ff   <= '{col: req_data.col, row: req_data.row, height: req_data.height};
            work_ff <= top_ff;
         end
         ST_CALC: begin
            if (slope_done) begin
               if (!second_ff || pop) s1_ff <= slope_out;
               if (pop) work_ff <= work_ff - 1'b1;
               if (cordic_go) begin
                  x_ff   <= CordicOne;
                  y_ff   <= 28'({sine_c, 8'd0});
                  z_ff   <= 22'sd0;
                  cnt_ff <= 4'd0;
               end
            end
         end
         ST_CORDIC: begin
            if (y_ff >= 28'sd0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + ang;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - ang;
            end
            cnt_ff <= cnt_ff + 4'd1;
         end
         ST_PUSH: if (push_ok) rsp_ff <= rsp_new;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A start request resets the hull to its single entry.
   a_start_clears_top: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.sweep_start |=> top_ff == '0)
      else $error("hull top not cleared by start request");

   // The slope unit only finishes while the sequencer waits for it.
   a_slope_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      slope_done |-> state_ff == ST_CALC)
      else $error("slope result arrived outside the wait state");

   // A response appears only after a hull push.
   a_rsp_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUSH)
      else $error("response raised without a push");

endmodule
`default_nettype wire

/* verif/horizon_sweep_occlusion_top_test.sv */
// Self-checking testbench for horizon_sweep_occlusion_top: a bit-exact hull and
// CORDIC predictor checks every response. Depends on hso_pkg and the block's RTL.
`timescale 1ns / 1ps
module horizon_sweep_occlusion_top_test;
   import hso_pkg::*;

   localparam int  HullDepth   = 1024;
   localparam int  CycleLimit  = 4000000;
   localparam int  SettleWait  = 400;
   localparam int  LongHold    = 3000;
   localparam int  RandomItems = 400;
   localparam logic [23:0] CellReset = 24'd64;

   localparam longint AtanStep [16] = '{
      524288, 309505, 163534, 83012, 41667, 20854, 10430, 5215,
      2608, 1304, 652, 326, 163, 81, 41, 20
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;

   // Predictor state: hull stack and the current cell size.
   longint  hull_c [HullDepth];
   longint  hull_r [HullDepth];
   longint  hull_h [HullDepth];
   int      hull_top_idx = 0;
   longint  cell_now = CellReset;

   rsp_type expected_rsp [$];
   int      mismatches = 0;
   int      unexpected = 0;
   int      rsp_seen = 0;
   int      req_sent = 0;
   int      cycles = 0;
   bit      send_gaps = 1'b1;
   bit      rsp_gaps = 1'b1;
   logic    hold_rsp = 1'b0;
   int      stall_left = 0;

   horizon_sweep_occlusion_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Integer square root, bit by bit.
   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_comp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
   endfunction

   // Shift right with rounding toward zero.
   function automatic longint shift_tz(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   // Q.16 slope from a sample to hull entry k, under the current cell size.
   function automatic longint slope_to_hull(longint c, longint r, longint h, int k);
      longint dx, dy, dz;
      longint unsigned len;
      dx = clamp_comp((c - hull_c[k]) * cell_now);
      dy = clamp_comp((r - hull_r[k]) * cell_now);
      dz = h - hull_h[k];
      len = root64(longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz));
      if (len == 0) return 0;
      return (-dz * 65536) / longint'(len);
   endfunction

   // Vectoring CORDIC arctangent of the clamped sine, rounded to a unit with pi/2 = 2^12.
   function automatic logic [12:0] occlusion_of(longint s);
      longint x, y, z, xs, ys;
      x = 64'sd16777216;
      z = 0;
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      y = s * 256;
      for (int i = 0; i < 16; i++) begin
         xs = shift_tz(x, i);
         ys = shift_tz(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + AtanStep[i];
         end else begin
            x = x - ys; y = y + xs; z = z - AtanStep[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 524288) z = 524288;
      return 13'((z + 128) >> 8);
   endfunction

   function automatic logic [9:0] grid_cell(longint v);
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[9:0];
   endfunction

   // Updates the hull for one accepted request and queues its response, if any.
   task automatic predict_hull_step(req_type q);
      longint c, r, h, sine;
      int top;
      rsp_type exp_rsp;
      c = longint'(q.col);
      r = longint'(q.row);
      h = longint'(q.height);
      if (q.sweep_start) begin
         hull_top_idx = 0;
         hull_c[0] = c; hull_r[0] = r; hull_h[0] = h;
         return;
      end
      top = (hull_top_idx > HullDepth - 1) ? HullDepth - 1 : hull_top_idx;
      while (top > 0 && slope_to_hull(c, r, h, top) < slope_to_hull(c, r, h, top - 1))
         top--;
      sine = slope_to_hull(c, r, h, top);
      if (top < HullDepth - 1) top++;
      hull_c[top] = c; hull_r[top] = r; hull_h[top] = h;
      hull_top_idx = top;
      exp_rsp.occlusion_part = occlusion_of(sine);
      exp_rsp.out_col = grid_cell(c);
      exp_rsp.out_row = grid_cell(r);
      expected_rsp.push_back(exp_rsp);
   endtask

   // Offers one request, waits for acceptance, then maybe idles.
   task automatic send_request(logic start, int c, int r, int h);
      req_type q;
      int gap;
      q.sweep_start = start;
      q.col = 12'(c);
      q.row = 12'(r);
      q.height = 24'(h);
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_hull_step(q);
      req_sent++;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every expected response has arrived.
   task automatic wait_drained();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_cell_size(logic [23:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      cell_now = v;
      @(posedge clock);
   endtask

   function automatic int clamp_grid(int v);
      if (v < -2) return -2;
      if (v > 1025) return 1025;
      return v;
   endfunction

   function automatic int clamp_height(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return int'(v);
   endfunction

   // One sweep line: a start request, then n samples along a random direction, some replaced by random noise.
   task automatic run_sweep(int n, int noise_pct);
      int c, r, dc, dr, amp;
      longint h;
      c = $urandom_range(0, 1027) - 2;
      r = $urandom_range(0, 1027) - 2;
      dc = $urandom_range(0, 2) - 1;
      dr = $urandom_range(0, 2) - 1;
      if (dc == 0 && dr == 0) dc = 1;
      amp = 1 << $urandom_range(4, 23);
      h = $signed($urandom_range(0, 2 * amp)) - amp;
      send_request(1'b1, c, r, clamp_height(h));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_request(1'b0, $urandom_range(0, 1027) - 2, $urandom_range(0, 1027) - 2,
                         int'($signed($urandom() << 8) >>> 8));
         end else begin
            c = clamp_grid(c + dc);
            r = clamp_grid(r + dr);
            h = h + $signed($urandom_range(0, 2 * amp)) - amp;
            send_request(1'b0, c, r, clamp_height(h));
         end
      end
   endtask

   // Response ready with random stalls, or held low by the hold-off process.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected response %p", rsp_data);
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (rsp_data.occlusion_part !== exp_rsp.occlusion_part ||
                rsp_data.out_col !== exp_rsp.out_col ||
                rsp_data.out_row !== exp_rsp.out_row) begin
               mismatches++;
               if (mismatches + unexpected <= 10)
                  $display("mismatch: expected %p, got %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // Field extremes, grid edges, flat and steep profiles.
   task automatic test_directed();
      send_request(1'b1, 0, 0, 0);
      send_request(1'b0, 1, 1, 8388607);
      send_request(1'b0, 2, 2, -8388608);
      send_request(1'b0, 3, 3, 0);
      send_request(1'b0, 4, 4, 8388607);
      send_request(1'b0, -2, -2, 100);
      send_request(1'b0, 1025, 1025, -100);
      send_request(1'b0, 1025, -2, 65536);
      send_request(1'b1, -2, 1025, -8388608);
      send_request(1'b0, -1, 1024, 8388607);
      send_request(1'b0, 0, 1023, -8388608);
      send_request(1'b0, 1, 1022, 0);
      // Repeating a position gives a zero length when heights match.
      send_request(1'b0, 1, 1022, 0);
      send_request(1'b1, 512, 512, 0);
      for (int i = 1; i <= 6; i++) send_request(1'b0, 512 + i, 512, (i % 2) ? 400000 : 0);
      wait_drained();
   endtask

   // Several cell sizes, the extremes among them, each with two sweeps.
   task automatic test_cell_sizes();
      logic [23:0] sizes [5] = '{24'd0, 24'hFFFFFF, 24'd1, 24'd65536, CellReset};
      foreach (sizes[i]) begin
         write_cell_size(sizes[i]);
         run_sweep($urandom_range(4, 10), 10);
         run_sweep($urandom_range(4, 10), 10);
      end
      wait_drained();
   endtask

   // A flat sweep longer than the hull, so the top index saturates.
   task automatic test_hull_full();
      send_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_request(1'b1, -2, 0, 1000);
      for (int i = 0; i < HullDepth + 8; i++) send_request(1'b0, clamp_grid(i - 1), 0, 1000);
      // A low sample after saturation compares against the overwritten top.
      send_request(1'b0, 1025, 1, -500000);
      send_gaps = 1'b1;
      rsp_gaps = 1'b1;
      wait_drained();
   endtask

   // Long response hold-off while requests keep coming, then a full drain.
   task automatic test_backpressure();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (LongHold) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         run_sweep(12, 0);
      join
      wait_drained();
   endtask

   // Random sweeps with noise until about the requested number of requests.
   task automatic test_random();
      int target;
      target = req_sent + RandomItems;
      while (req_sent < target) begin
         if ($urandom_range(0, 7) == 0) write_cell_size(24'($urandom_range(0, 24'hFFFFFF)));
         send_gaps = ($urandom_range(0, 4) != 0);
         rsp_gaps = ($urandom_range(0, 4) != 0);
         run_sweep($urandom_range(1, 30), 12);
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_cell_sizes();
      test_hull_full();
      test_backpressure();
      test_random();
      $display("Sent %0d requests over directed, cell size, full hull, hold-off", req_sent);
      $display("and random sweep tests; checked %0d responses.", rsp_seen);
      if (mismatches == 0 && unexpected == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing",
                  mismatches, unexpected, expected_rsp.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
